[src/cga_pkg.sv]
// Shared types, codes and constants for the clock generator allocator.
// Used by cga_ctrl, cga_datapath and clock_generator_allocator_core.
package cga_pkg;

  localparam int HZ_W       = 26;
  localparam int PID_W      = 6;
  localparam int GEN_W      = 4;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam int DEF_GENERATORS = 9;
  localparam int DEF_SLOTS      = 7;
  localparam int LOCKED_GENS    = 3;

  localparam logic [HZ_W-1:0] FAST_SOURCE_HZ = HZ_W'(48000000);
  localparam logic [HZ_W-1:0] SLOW_SOURCE_HZ = HZ_W'(8000000);

  // request actions
  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_GIVEN  = 2'd1;
  localparam logic [1:0] ACT_DETACH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_INVALID      = 2'd1;
  localparam logic [1:0] ST_NO_RESOURCES = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       fscan_step;
    logic       pick_match;
    logic       pick_idle;
    logic       pick_given;
    logic       cfg_start;
    logic       halve;
    logic       cfg_write;
    logic       scan_attach;
    logic       scan_detach;
    logic       slot_write;
    logic       respond;
    logic [1:0] resp_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       given_bad;
    logic       fscan_last;
    logic       match_found;
    logic       idle_ok;
    logic       freq_nonzero;
    logic       halve_done;
    logic       scan_busy;
    logic       slot_hit;
    logic       out_free;
  } sts_t;

  // frequency of a generator after reset
  function automatic logic [HZ_W-1:0] reset_freq(input int unsigned g);
    logic [HZ_W-1:0] f;
    case (g)
      0:       f = FAST_SOURCE_HZ;
      1, 2:    f = SLOW_SOURCE_HZ;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

[src/cga_ctrl.sv]
// Sequencing state machine of the clock generator allocator.
// Depends on cga_pkg; drives cga_datapath through cmd_t and reads sts_t.
module cga_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cga_pkg::sts_t sts,
  output cga_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_FSCAN,
    S_DECIDE,
    S_HALVE,
    S_ASTART,
    S_ASCAN,
    S_DSCAN,
    S_RESP
  } state_t;

  state_t     state, state_next;
  logic [1:0] resp_code, resp_code_next;

  assign in_ready = (state == S_IDLE);

  // decode state into datapath commands
  always_comb begin
    cmd            = '0;
    state_next     = state;
    resp_code_next = resp_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          cga_pkg::ACT_ALLOC: begin
            state_next = S_FSCAN;
          end
          cga_pkg::ACT_GIVEN: begin
            if (sts.given_bad) begin
              resp_code_next = cga_pkg::ST_INVALID;
              state_next     = S_RESP;
            end else if (sts.freq_nonzero) begin
              resp_code_next = cga_pkg::ST_NO_RESOURCES;
              state_next     = S_RESP;
            end else begin
              cmd.pick_given = 1'b1;
              cmd.cfg_start  = 1'b1;
              state_next     = S_HALVE;
            end
          end
          cga_pkg::ACT_DETACH: begin
            cmd.scan_detach = 1'b1;
            state_next      = S_DSCAN;
          end
          default: begin
            resp_code_next = cga_pkg::ST_INVALID;
            state_next     = S_RESP;
          end
        endcase
      end
      S_FSCAN: begin
        cmd.fscan_step = 1'b1;
        if (sts.fscan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.match_found) begin
          cmd.pick_match = 1'b1;
          state_next     = S_ASTART;
        end else if (sts.idle_ok) begin
          cmd.pick_idle = 1'b1;
          cmd.cfg_start = 1'b1;
          state_next    = S_HALVE;
        end else begin
          resp_code_next = cga_pkg::ST_NO_RESOURCES;
          state_next     = S_RESP;
        end
      end
      S_HALVE: begin
        if (sts.halve_done) begin
          cmd.cfg_write = 1'b1;
          state_next    = S_ASTART;
        end else begin
          cmd.halve = 1'b1;
        end
      end
      S_ASTART: begin
        cmd.scan_attach = 1'b1;
        state_next      = S_ASCAN;
      end
      S_ASCAN: begin
        // a full slot table still reports success
        if (!sts.scan_busy) begin
          cmd.slot_write = sts.slot_hit;
          resp_code_next = cga_pkg::ST_OK;
          state_next     = S_RESP;
        end
      end
      S_DSCAN: begin
        if (!sts.scan_busy) begin
          cmd.slot_write = sts.slot_hit;
          resp_code_next = sts.slot_hit ? cga_pkg::ST_OK : cga_pkg::ST_INVALID;
          state_next     = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = resp_code;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold state and the pending result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resp_code <= cga_pkg::ST_OK;
    end else begin
      state     <= state_next;
      resp_code <= resp_code_next;
    end
  end

endmodule

[src/cga_datapath.sv]
// Generator table, slot memory, scan counters and result register.
// Depends on cga_pkg; commanded by cga_ctrl.
module cga_datapath #(
  parameter int GENERATORS          = cga_pkg::DEF_GENERATORS,
  parameter int SLOTS_PER_GENERATOR = cga_pkg::DEF_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [cga_pkg::IN_DATA_W-1:0]    in_data,
  input  cga_pkg::cmd_t                    cmd,
  output cga_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cga_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int HW  = cga_pkg::HZ_W;
  localparam int PW  = cga_pkg::PID_W;
  localparam int GW  = $clog2(GENERATORS);
  localparam int GCW = $clog2(GENERATORS + 1);
  localparam int SCW = $clog2(SLOTS_PER_GENERATOR + 1);
  localparam int NE  = GENERATORS * SLOTS_PER_GENERATOR;
  localparam int AW  = $clog2(NE);

  // latched request
  logic [1:0]    act;
  logic [PW-1:0] pid;
  logic [HW-1:0] want;
  logic [3:0]    given;

  // generator table
  logic [HW-1:0]  freq [GENERATORS];
  logic [GCW-1:0] gcnt;
  logic           match_found, idle_found;
  logic [GW-1:0]  match_g, idle_g, sel_g;
  logic [HW-1:0]  fpick, granted;

  // slot memory with per-entry valid bits
  logic [PW-1:0] slot_mem [NE];
  logic [NE-1:0] slot_vld;

  // slot scan: issue and check stages
  logic           iv, det;
  logic [AW-1:0]  ia;
  logic [GW-1:0]  ig;
  logic [SCW-1:0] scnt;
  logic           cv, rvb;
  logic [GW-1:0]  cg;
  logic [AW-1:0]  caddr;
  logic [PW-1:0]  rdata;
  logic           hit;
  logic [GW-1:0]  hit_g;
  logic [AW-1:0]  hit_addr;

  // result register
  logic [1:0]    o_status;
  logic [3:0]    o_used;
  logic [HW-1:0] o_granted;

  logic [HW-1:0] cur_freq, half;
  logic [PW-1:0] slot_data, slot_target;
  logic          slot_eq, issue_last, cur_locked;
  logic [AW-1:0] base;
  logic          resp_ok;

  assign cur_freq    = freq[gcnt[GW-1:0]];
  assign cur_locked  = (gcnt < GCW'(cga_pkg::LOCKED_GENS));
  assign half        = {1'b0, fpick[HW-1:1]};
  assign slot_data   = rvb ? rdata : '0;
  assign slot_target = det ? pid : '0;
  assign slot_eq     = (slot_data == slot_target);
  assign issue_last  = (scnt == SCW'(SLOTS_PER_GENERATOR - 1)) &&
                       (!det || ig == GW'(GENERATORS - 1));
  assign base        = AW'(sel_g) * AW'(SLOTS_PER_GENERATOR);
  assign resp_ok     = (cmd.resp_status == cga_pkg::ST_OK);

  // status toward the controller
  always_comb begin
    sts              = '0;
    sts.action       = act;
    sts.given_bad    = ({1'b0, given} >= 5'(GENERATORS));
    sts.fscan_last   = (gcnt == GCW'(GENERATORS - 1));
    sts.match_found  = match_found;
    sts.idle_ok      = idle_found && (idle_g != GW'(GENERATORS - 1));
    sts.freq_nonzero = (cur_freq != '0);
    sts.halve_done   = !(half > want);
    sts.scan_busy    = iv || cv;
    sts.slot_hit     = hit;
    sts.out_free     = !out_valid || out_ready;
  end

  // generator frequency table; locked generators keep their setting
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GENERATORS; i++) begin
        freq[i] <= cga_pkg::reset_freq(i);
      end
    end else if (cmd.cfg_write && (sel_g >= GW'(cga_pkg::LOCKED_GENS))) begin
      freq[sel_g] <= fpick;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.slot_write) begin
      slot_mem[hit_addr] <= det ? '0 : pid;
    end
    if (iv) begin
      rdata <= slot_mem[ia];
    end
  end

  // request capture, generator scan, frequency pick, slot scan, result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld    <= '0;
      match_found <= 1'b0;
      idle_found  <= 1'b0;
      iv          <= 1'b0;
      cv          <= 1'b0;
      rvb         <= 1'b0;
      det         <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
      act         <= cga_pkg::ACT_ALLOC;
    end else begin
      // capture request
      if (cmd.load) begin
        act         <= in_data[1:0];
        pid         <= in_data[7:2];
        want        <= in_data[33:8];
        given       <= in_data[37:34];
        gcnt        <= (in_data[1:0] == cga_pkg::ACT_GIVEN) ? GCW'(in_data[37:34]) : '0;
        match_found <= 1'b0;
        idle_found  <= 1'b0;
      end

      // walk generators: first frequency match, first unlocked idle one
      if (cmd.fscan_step) begin
        if (!match_found && cur_freq == want) begin
          match_found <= 1'b1;
          match_g     <= gcnt[GW-1:0];
        end
        if (!idle_found && !cur_locked && cur_freq == '0) begin
          idle_found <= 1'b1;
          idle_g     <= gcnt[GW-1:0];
        end
        if (gcnt != GCW'(GENERATORS - 1)) begin
          gcnt <= gcnt + GCW'(1);
        end
      end

      // choose generator
      if (cmd.pick_match) begin
        sel_g   <= match_g;
        granted <= want;
      end
      if (cmd.pick_idle) begin
        sel_g <= idle_g;
      end
      if (cmd.pick_given) begin
        sel_g <= gcnt[GW-1:0];
      end

      // source selection and halving
      if (cmd.cfg_start) begin
        fpick <= (want > cga_pkg::SLOW_SOURCE_HZ) ? cga_pkg::FAST_SOURCE_HZ
                                                  : cga_pkg::SLOW_SOURCE_HZ;
      end
      if (cmd.halve) begin
        fpick <= half;
      end
      if (cmd.cfg_write) begin
        granted <= fpick;
      end

      // start slot scan
      if (cmd.scan_attach || cmd.scan_detach) begin
        iv   <= 1'b1;
        det  <= cmd.scan_detach;
        ia   <= cmd.scan_detach ? '0 : base;
        ig   <= cmd.scan_detach ? '0 : sel_g;
        scnt <= '0;
        hit  <= 1'b0;
      end

      // issue stage: advance one slot a cycle
      cv <= iv;
      if (iv) begin
        rvb   <= slot_vld[ia];
        cg    <= ig;
        caddr <= ia;
        ia    <= ia + AW'(1);
        if (scnt == SCW'(SLOTS_PER_GENERATOR - 1)) begin
          scnt <= '0;
          ig   <= ig + GW'(1);
        end else begin
          scnt <= scnt + SCW'(1);
        end
        if (issue_last) begin
          iv <= 1'b0;
        end
      end

      // check stage: attach keeps the first empty slot; detach keeps the
      // first match of the highest generator
      if (cv && slot_eq) begin
        if (det) begin
          if (!(hit && hit_g == cg)) begin
            hit      <= 1'b1;
            hit_g    <= cg;
            hit_addr <= caddr;
          end
        end else if (!hit) begin
          hit      <= 1'b1;
          hit_addr <= caddr;
        end
      end

      if (cmd.slot_write) begin
        slot_vld[hit_addr] <= 1'b1;
      end

      // result register
      if (cmd.respond) begin
        out_valid <= 1'b1;
        o_status  <= cmd.resp_status;
        o_used    <= !resp_ok ? 4'd0 : ((act == cga_pkg::ACT_DETACH) ? 4'(hit_g) : 4'(sel_g));
        o_granted <= (resp_ok && act != cga_pkg::ACT_DETACH) ? granted : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // status, generator, frequency from the lowest bit up
  assign out_data = {o_granted, o_used, o_status};

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> o_status != 2'd3)
    else $error("result status out of range");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_status != cga_pkg::ST_OK |-> o_used == 4'd0 && o_granted == '0)
    else $error("error result carries generator or frequency");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_status == cga_pkg::ST_OK |-> {1'b0, o_used} < 5'(GENERATORS))
    else $error("result generator out of range");

  a_check_follows_issue: assert property (@(posedge clk) disable iff (rst)
    cv |-> $past(iv))
    else $error("slot check without a read issued");

endmodule

[src/clock_generator_allocator_core.sv]
// Clock generator allocator: top level joining controller and datapath.
// Depends on cga_pkg, cga_ctrl and cga_datapath.
//
// Requests enter on s_axis_*; one result per request leaves on m_axis_*.
// Allocate scans the generators one per cycle for a frequency match or the
// lowest unlocked idle one, halves the chosen source one step a cycle, then
// scans that generator's slots one per cycle to attach the peripheral.
// Detach scans every slot of every generator, one per cycle, through the
// slot memory's single read port.
// Allocate skips the halving when a generator already runs at the requested
// frequency; a bad action, or a refused given request, gets its result with no scan.
// One request is worked at a time; the next is taken once the result is
// loaded into the output register, even while that result waits.
// Reset restores the generator table (0 at 48 MHz, 1 and 2 at 8 MHz, all
// three locked) and marks every slot empty at once; no clearing pass.
// When m_axis_tready is low the result holds and the controller waits.
module clock_generator_allocator_core #(
  parameter int GENERATORS          = cga_pkg::DEF_GENERATORS,
  parameter int SLOTS_PER_GENERATOR = cga_pkg::DEF_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action[1:0], peripheral_id[7:2], requested_hz[33:8], generator[37:34], zero[39:38]
  input  logic [cga_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], generator_used[5:2], granted_hz[31:6]
  output logic [cga_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  cga_pkg::cmd_t cmd;
  cga_pkg::sts_t sts;

  cga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cga_datapath #(
    .GENERATORS          (GENERATORS),
    .SLOTS_PER_GENERATOR (SLOTS_PER_GENERATOR)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
